FILE: design/ddmq_pkg.sv
// ----------------------------------------------------------------------------
// ddmq_pkg
// Shared types, codes and constants of the motion command queue.
// ----------------------------------------------------------------------------
package ddmq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 8;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEPS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_GAIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_GAIN     = 2'd3;

    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_GOTO     = 3'd1;
    localparam logic [2:0] ACT_CLEAR    = 3'd2;
    localparam logic [2:0] ACT_DISPATCH = 3'd3;
    localparam logic [2:0] ACT_SET_POSE = 3'd4;

    localparam logic [2:0] DIR_STOP  = 3'd0;
    localparam logic [2:0] DIR_FWD   = 3'd1;
    localparam logic [2:0] DIR_BACK  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    localparam logic [23:0] STEP_MAX     = 24'hFF_FFFF;
    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
    localparam logic [31:0] OUT_MAX      = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0]         action;
        logic [2:0]         direction;
        logic [23:0]        step_count;
        logic signed [11:0] x_value;
        logic signed [11:0] y_value;
        logic [15:0]        heading_value;
    } t_cmd;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] left_steps;
        logic signed [31:0] right_steps;
        logic               stop_motors;
        logic               sensor_active;
        logic [2:0]         active_direction;
        logic [3:0]         queue_count;
    } t_res;

    // arctangent of 2^-i as a fraction of a full turn, 2^32 per turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680862;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/ddmq_cordic.sv
// ----------------------------------------------------------------------------
// ddmq_cordic
// Iterative vectoring CORDIC: one rotation step per cycle, gives the
// unscaled radius and the bearing as a 32-bit turn fraction.
// ----------------------------------------------------------------------------
module ddmq_cordic #(
    parameter int CORDIC_STEPS = ddmq_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [12:0] i_dx,
    input  logic signed [12:0] i_dy,
    output logic               o_done,
    output logic signed [31:0] o_x,
    output logic [31:0]        o_z
);

    localparam int IW = $clog2(CORDIC_STEPS);

    logic              r_run;
    logic              r_done;
    logic [IW-1:0]     r_i;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [31:0]       r_z;

    logic signed [31:0] dx_ext;
    logic signed [31:0] dy_ext;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [31:0]        at;

    assign dx_ext = 32'(i_dx);
    assign dy_ext = 32'(i_dy);
    assign sx     = r_x >>> r_i;
    assign sy     = r_y >>> r_i;
    assign at     = ddmq_pkg::atan_turn(5'(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_i   <= '0;
                // left half plane: flip the vector and start at half a turn
                if (i_dx < 0) begin
                    r_x <= (-dx_ext) <<< 16;
                    r_y <= (-dy_ext) <<< 16;
                    r_z <= 32'h8000_0000;
                end else begin
                    r_x <= dx_ext <<< 16;
                    r_y <= dy_ext <<< 16;
                    r_z <= '0;
                end
            end else if (r_run) begin
                if (r_y >= 0) begin
                    r_x <= r_x + sy;
                    r_y <= r_y - sx;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - sy;
                    r_y <= r_y + sx;
                    r_z <= r_z - at;
                end
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_z    = r_z;

endmodule

FILE: design/diff_drive_motion_command_queue_unit.sv
// ----------------------------------------------------------------------------
// diff_drive_motion_command_queue_unit
// Motion command FIFO with pose, go-to-point planner and wheel dispatch.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             i_cmd (t_cmd)
// result    out        o_done, one-cycle strobe  o_result (t_res)
// config    in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// Add, clear, set pose, unknown actions and dispatch on an empty queue:
// the result is registered and follows in the cycle after start.
// Dispatch: queue memory read, then gain multiply, then the result.
// Goto: one-step-per-cycle CORDIC, then three shared 32x32 multiplier passes.
// Reset is synchronous and needs no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module diff_drive_motion_command_queue_unit #(
    parameter int QUEUE_DEPTH  = ddmq_pkg::QUEUE_DEPTH_DEF,
    parameter int CORDIC_STEPS = ddmq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  ddmq_pkg::t_cmd                     i_cmd,
    output logic                               o_done,
    output ddmq_pkg::t_res                     o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ddmq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ddmq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_DISP, S_COR, S_RAD, S_FST, S_TURN, S_PUSH_T, S_PUSH_F
    } t_state;

    t_state          r_state, n_state;
    logic [15:0]     r_spm, n_spm;
    logic [19:0]     r_tpr, n_tpr;
    logic [7:0]      r_fgain, n_fgain;
    logic [7:0]      r_rgain, n_rgain;
    logic [QW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic signed [11:0] r_px, n_px;
    logic signed [11:0] r_py, n_py;
    logic [15:0]     r_head, n_head;
    logic [2:0]      r_cur_dir, n_cur_dir;
    logic            r_sensor, n_sensor;
    logic            r_done, n_done;
    ddmq_pkg::t_res  r_res, n_res;
    logic            r_zero, n_zero;
    logic            r_ok, n_ok;
    logic [15:0]     r_bearing, n_bearing;
    logic [23:0]     r_fsteps, n_fsteps;
    logic [23:0]     r_tsteps, n_tsteps;
    logic [63:0]     r_prod;
    logic [26:0]     r_rd_data;
    logic [26:0]     r_mem [QUEUE_DEPTH];

    logic [31:0]     mul_a, mul_b;
    logic            mem_we;
    logic [26:0]     mem_wdata;
    logic            cor_start, cor_done;
    logic signed [31:0] cor_x;
    logic [31:0]     cor_z;
    logic signed [12:0] dx, dy;
    logic            full;
    logic [QW-1:0]   wr_ptr_inc, rd_ptr_inc;
    logic [15:0]     turn_d;
    logic [16:0]     turn_mag;
    logic [31:0]     disp_n;
    logic [2:0]      head_dir;
    logic [15:0]     z_round;

    assign dx    = 13'(i_cmd.x_value) - 13'(r_px);
    assign dy    = 13'(i_cmd.y_value) - 13'(r_py);
    assign full  = (r_count == CW'(QUEUE_DEPTH));
    assign wr_ptr_inc = (r_wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_ptr_inc = (r_rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign turn_d   = r_bearing - r_head;
    assign turn_mag = turn_d[15] ? (17'h10000 - 17'(turn_d)) : 17'(turn_d);
    assign disp_n   = (r_prod[31:0] > ddmq_pkg::OUT_MAX) ? ddmq_pkg::OUT_MAX
                                                          : r_prod[31:0];
    assign head_dir = r_rd_data[26:24];
    assign z_round  = 16'((cor_z + 32'h8000) >> 16);

    ddmq_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_z     (cor_z)
    );

    always_comb begin
        n_state   = r_state;
        n_spm     = r_spm;
        n_tpr     = r_tpr;
        n_fgain   = r_fgain;
        n_rgain   = r_rgain;
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_count   = r_count;
        n_px      = r_px;
        n_py      = r_py;
        n_head    = r_head;
        n_cur_dir = r_cur_dir;
        n_sensor  = r_sensor;
        n_done    = 1'b0;
        n_zero    = r_zero;
        n_ok      = r_ok;
        n_bearing = r_bearing;
        n_fsteps  = r_fsteps;
        n_tsteps  = r_tsteps;
        n_res     = r_res;
        mul_a     = '0;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_wdata = '0;
        cor_start = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                ddmq_pkg::CFG_STEPS_PER_MM: n_spm   = i_cfg_data[15:0];
                ddmq_pkg::CFG_TURN_STEPS:   n_tpr   = i_cfg_data;
                ddmq_pkg::CFG_FWD_GAIN:     n_fgain = i_cfg_data[7:0];
                ddmq_pkg::CFG_ROT_GAIN:     n_rgain = i_cfg_data[7:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res = '0;
                    case (i_cmd.action)
                        ddmq_pkg::ACT_ADD: begin
                            if (i_cmd.direction <= ddmq_pkg::DIR_RIGHT && !full) begin
                                mem_we    = 1'b1;
                                mem_wdata = {i_cmd.direction, i_cmd.step_count};
                                n_wr_ptr  = wr_ptr_inc;
                                n_count   = r_count + 1'b1;
                                n_res.accepted = 1'b1;
                            end
                            n_done = 1'b1;
                        end
                        ddmq_pkg::ACT_GOTO: begin
                            cor_start = 1'b1;
                            n_zero    = (dx == '0) && (dy == '0);
                            n_state   = S_COR;
                        end
                        ddmq_pkg::ACT_CLEAR: begin
                            n_count  = '0;
                            n_wr_ptr = r_rd_ptr;
                            n_done   = 1'b1;
                        end
                        ddmq_pkg::ACT_DISPATCH: begin
                            if (r_count != '0) begin
                                n_state = S_HEAD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        ddmq_pkg::ACT_SET_POSE: begin
                            n_px   = i_cmd.x_value;
                            n_py   = i_cmd.y_value;
                            n_head = i_cmd.heading_value;
                            n_done = 1'b1;
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_HEAD: begin
                // head entry is on the read register; scale by the gain
                mul_a = 32'(r_rd_data[23:0]);
                if (head_dir == ddmq_pkg::DIR_FWD || head_dir == ddmq_pkg::DIR_BACK) begin
                    mul_b = 32'(r_fgain);
                end else begin
                    mul_b = 32'(r_rgain);
                end
                n_state = S_DISP;
            end
            S_DISP: begin
                n_sensor  = (r_count != CW'(1));
                n_cur_dir = head_dir;
                n_res.accepted = 1'b1;
                case (head_dir)
                    ddmq_pkg::DIR_FWD: begin
                        n_res.left_steps  = disp_n;
                        n_res.right_steps = disp_n;
                    end
                    ddmq_pkg::DIR_BACK: begin
                        n_res.left_steps  = -disp_n;
                        n_res.right_steps = -disp_n;
                    end
                    ddmq_pkg::DIR_LEFT: begin
                        n_res.left_steps  = disp_n;
                        n_res.right_steps = -disp_n;
                    end
                    ddmq_pkg::DIR_RIGHT: begin
                        n_res.left_steps  = -disp_n;
                        n_res.right_steps = disp_n;
                    end
                    default: n_res.stop_motors = 1'b1;
                endcase
                n_rd_ptr = rd_ptr_inc;
                n_count  = r_count - 1'b1;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_COR: begin
                if (cor_done) begin
                    mul_a     = (r_zero || cor_x < 0) ? '0 : cor_x;
                    mul_b     = ddmq_pkg::INV_GAIN_Q32;
                    n_bearing = r_zero ? '0 : z_round;
                    n_state   = S_RAD;
                end
            end
            S_RAD: begin
                mul_a   = r_prod[63:32];
                mul_b   = 32'(r_spm);
                n_state = S_FST;
            end
            S_FST: begin
                n_fsteps = (r_prod[63:48] != '0) ? ddmq_pkg::STEP_MAX : r_prod[47:24];
                mul_a    = 32'(turn_mag);
                mul_b    = 32'(r_tpr);
                n_state  = S_TURN;
            end
            S_TURN: begin
                n_tsteps = (r_prod[63:40] != '0) ? ddmq_pkg::STEP_MAX : r_prod[39:16];
                n_state  = S_PUSH_T;
            end
            S_PUSH_T: begin
                n_ok = 1'b1;
                if (turn_d != '0) begin
                    if (full) begin
                        n_ok = 1'b0;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = {turn_d[15] ? ddmq_pkg::DIR_RIGHT : ddmq_pkg::DIR_LEFT,
                                     r_tsteps};
                        n_wr_ptr  = wr_ptr_inc;
                        n_count   = r_count + 1'b1;
                    end
                end
                n_state = S_PUSH_F;
            end
            S_PUSH_F: begin
                if (!full) begin
                    mem_we    = 1'b1;
                    mem_wdata = {ddmq_pkg::DIR_FWD, r_fsteps};
                    n_wr_ptr  = wr_ptr_inc;
                    n_count   = r_count + 1'b1;
                end
                n_res.accepted = r_ok && !full;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        n_res.sensor_active    = n_sensor;
        n_res.active_direction = n_cur_dir;
        n_res.queue_count      = 4'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_spm     <= 16'd272;
            r_tpr     <= 20'd1000;
            r_fgain   <= 8'd1;
            r_rgain   <= 8'd1;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_count   <= '0;
            r_px      <= '0;
            r_py      <= '0;
            r_head    <= '0;
            r_cur_dir <= ddmq_pkg::DIR_STOP;
            r_sensor  <= 1'b1;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_spm     <= n_spm;
            r_tpr     <= n_tpr;
            r_fgain   <= n_fgain;
            r_rgain   <= n_rgain;
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_count   <= n_count;
            r_px      <= n_px;
            r_py      <= n_py;
            r_head    <= n_head;
            r_cur_dir <= n_cur_dir;
            r_sensor  <= n_sensor;
            r_done    <= n_done;
        end
        r_res     <= n_res;
        r_zero    <= n_zero;
        r_ok      <= n_ok;
        r_bearing <= n_bearing;
        r_fsteps  <= n_fsteps;
        r_tsteps  <= n_tsteps;
        r_prod    <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item neither in work nor finished");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |-> (r_count != '0))
        else $error("dispatch from empty queue");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motion command queue: it drives commands and
// config writes, predicts every result in-bench, and compares each field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = ddmq_pkg::QUEUE_DEPTH_DEF;
    localparam int CSTEPS    = ddmq_pkg::CORDIC_STEPS_DEF;
    localparam int WDOG_MAX  = 5000;
    localparam int IDLE_WAIT = 40;

    localparam logic [31:0] ATAN_TBL [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    ddmq_pkg::t_cmd i_cmd = '0;
    logic o_done;
    ddmq_pkg::t_res o_result;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [ddmq_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ddmq_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    always #2 i_clk = ~i_clk;

    diff_drive_motion_command_queue_unit dut (.*);

    // model of the block
    logic [15:0] mdl_spm;
    logic [19:0] mdl_turn;
    logic [7:0]  mdl_fgain, mdl_rgain;
    logic [2:0]  q_dir [DEPTH];
    logic [23:0] q_steps [DEPTH];
    int          q_count;
    int          pose_x, pose_y;
    logic [15:0] pose_hdg;
    logic [2:0]  cur_dir;
    logic        sensor_on;

    ddmq_pkg::t_cmd pending_cmds [$];
    ddmq_pkg::t_res expected_results [$];
    int   errors = 0;
    int   idle_pct = 0;
    int   wdog = 0;

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic bit push_cmd(logic [2:0] d, longint unsigned s);
        if (q_count >= DEPTH) return 1'b0;
        q_dir[q_count] = d;
        q_steps[q_count] = (s > 64'hFF_FFFF) ? 24'hFF_FFFF : s[23:0];
        q_count++;
        return 1'b1;
    endfunction

    function automatic bit plan_goto(int tx, int ty);
        longint dx, dy, cx, cy, sx, sy;
        logic [31:0] z;
        logic [15:0] bearing, diff, mag;
        longint unsigned rq, fs, ts;
        bit ok;
        ok = 1'b1;
        z = 32'd0;
        dx = tx - pose_x;
        dy = ty - pose_y;
        if (dx < 0) begin
            cx = -dx * 65536;
            cy = -dy * 65536;
            z = 32'h8000_0000;
        end else begin
            cx = dx * 65536;
            cy = dy * 65536;
        end
        for (int i = 0; i < CSTEPS; i++) begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy >= 0) begin
                cx += sy; cy -= sx; z += ATAN_TBL[i];
            end else begin
                cx -= sy; cy += sx; z -= ATAN_TBL[i];
            end
        end
        if (dx == 0 && dy == 0) begin
            bearing = 16'd0;
            cx = 0;
        end else begin
            bearing = 16'((z + 32'h8000) >> 16);
        end
        if (cx < 0) cx = 0;
        rq = (longint'(cx) * 64'd2608131496) >> 32;
        fs = (rq * mdl_spm) >> 24;
        diff = bearing - pose_hdg;
        if (diff != 16'd0) begin
            mag = diff[15] ? 16'(17'h10000 - diff) : diff;
            ts = (longint'(mag) * mdl_turn) >> 16;
            ok = push_cmd(diff[15] ? ddmq_pkg::DIR_RIGHT : ddmq_pkg::DIR_LEFT, ts) && ok;
        end
        ok = push_cmd(ddmq_pkg::DIR_FWD, fs) && ok;
        return ok;
    endfunction

    function automatic ddmq_pkg::t_res predict_result(ddmq_pkg::t_cmd c);
        ddmq_pkg::t_res r;
        longint n;
        r = '0;
        case (c.action)
            ddmq_pkg::ACT_ADD: if (c.direction <= ddmq_pkg::DIR_RIGHT)
                r.accepted = push_cmd(c.direction, 64'(c.step_count));
            ddmq_pkg::ACT_GOTO: r.accepted = plan_goto(c.x_value, c.y_value);
            ddmq_pkg::ACT_CLEAR: q_count = 0;
            ddmq_pkg::ACT_DISPATCH: if (q_count > 0) begin
                sensor_on = (q_count != 1);
                cur_dir = q_dir[0];
                n = q_steps[0] * ((q_dir[0] == ddmq_pkg::DIR_FWD ||
                                   q_dir[0] == ddmq_pkg::DIR_BACK)
                    ? longint'(mdl_fgain) : longint'(mdl_rgain));
                if (n > 64'h7FFF_FFFF) n = 64'h7FFF_FFFF;
                case (q_dir[0])
                    ddmq_pkg::DIR_FWD: begin
                        r.left_steps = 32'(n);  r.right_steps = 32'(n);
                    end
                    ddmq_pkg::DIR_BACK: begin
                        r.left_steps = 32'(-n); r.right_steps = 32'(-n);
                    end
                    ddmq_pkg::DIR_LEFT: begin
                        r.left_steps = 32'(n);  r.right_steps = 32'(-n);
                    end
                    ddmq_pkg::DIR_RIGHT: begin
                        r.left_steps = 32'(-n); r.right_steps = 32'(n);
                    end
                    default: r.stop_motors = 1'b1;
                endcase
                for (int k = 0; k + 1 < q_count; k++) begin
                    q_dir[k] = q_dir[k+1];
                    q_steps[k] = q_steps[k+1];
                end
                q_count--;
                r.accepted = 1'b1;
            end
            ddmq_pkg::ACT_SET_POSE: begin
                pose_x = c.x_value;
                pose_y = c.y_value;
                pose_hdg = c.heading_value;
            end
            default: ;
        endcase
        r.sensor_active = sensor_on;
        r.active_direction = cur_dir;
        r.queue_count = 4'(q_count);
        return r;
    endfunction

    // driver: keep start high across back-to-back transfers
    always @(posedge i_clk) begin
        if (start && !busy) begin
            expected_results.push_back(predict_result(i_cmd));
            void'(pending_cmds.pop_front());
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if ((start && busy) ) begin
            start <= 1'b1;
        end else begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_cmd <= pending_cmds[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                ddmq_pkg::t_res e;
                e = expected_results.pop_front();
                if (o_result.accepted !== e.accepted)
                    report("accepted", o_result.accepted, e.accepted);
                if (o_result.left_steps !== e.left_steps)
                    report("left_steps", o_result.left_steps, e.left_steps);
                if (o_result.right_steps !== e.right_steps)
                    report("right_steps", o_result.right_steps, e.right_steps);
                if (o_result.stop_motors !== e.stop_motors)
                    report("stop_motors", o_result.stop_motors, e.stop_motors);
                if (o_result.sensor_active !== e.sensor_active)
                    report("sensor_active", o_result.sensor_active, e.sensor_active);
                if (o_result.active_direction !== e.active_direction)
                    report("active_direction", o_result.active_direction,
                           e.active_direction);
                if (o_result.queue_count !== e.queue_count)
                    report("queue_count", o_result.queue_count, e.queue_count);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic ddmq_pkg::t_cmd mk(logic [2:0] a, logic [2:0] d, logic [23:0] s,
                                          int x, int y, logic [15:0] h);
        ddmq_pkg::t_cmd c;
        c.action = a; c.direction = d; c.step_count = s;
        c.x_value = 12'(x); c.y_value = 12'(y); c.heading_value = h;
        return c;
    endfunction

    function automatic ddmq_pkg::t_cmd rand_cmd();
        ddmq_pkg::t_cmd c;
        int p;
        c.action = 3'($urandom);
        c.direction = 3'($urandom_range(4));
        c.step_count = 24'($urandom);
        c.x_value = 12'($urandom);
        c.y_value = 12'($urandom);
        c.heading_value = 16'($urandom);
        p = $urandom_range(99);
        if (p < 32) c.action = ddmq_pkg::ACT_ADD;
        else if (p < 52) c.action = ddmq_pkg::ACT_GOTO;
        else if (p < 85) c.action = ddmq_pkg::ACT_DISPATCH;
        else if (p < 89) c.action = ddmq_pkg::ACT_CLEAR;
        else if (p < 97) c.action = ddmq_pkg::ACT_SET_POSE;
        if ($urandom_range(19) == 0) c.direction = 3'($urandom_range(7, 5));
        case ($urandom_range(3))
            0: c.step_count = $urandom_range(1) ? 24'hFF_FFFF : 24'd0;
            1: c.step_count = 24'($urandom_range(2000));
            default: ;
        endcase
        return c;
    endfunction

    // write one register through the config channel; valid stays high
    task automatic cfg_write(logic [ddmq_pkg::CFG_IDX_W-1:0] idx,
                             logic [ddmq_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            ddmq_pkg::CFG_STEPS_PER_MM: mdl_spm = val[15:0];
            ddmq_pkg::CFG_TURN_STEPS:   mdl_turn = val[19:0];
            ddmq_pkg::CFG_FWD_GAIN:     mdl_fgain = val[7:0];
            default:                    mdl_rgain = val[7:0];
        endcase
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    initial begin
        logic [ddmq_pkg::CFG_DATA_W-1:0] cfg [4];
        mdl_spm = 16'd272; mdl_turn = 20'd1000; mdl_fgain = 8'd1; mdl_rgain = 8'd1;
        q_count = 0; pose_x = 0; pose_y = 0; pose_hdg = 16'd0;
        cur_dir = ddmq_pkg::DIR_STOP; sensor_on = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each direction, step extremes, invalid direction, full queue
        pending_cmds.push_back(mk(ddmq_pkg::ACT_DISPATCH, ddmq_pkg::DIR_STOP, 0, 0, 0, 0));
        for (int d = 0; d <= 4; d++)
            pending_cmds.push_back(mk(ddmq_pkg::ACT_ADD, 3'(d),
                                      d[0] ? 24'hFF_FFFF : 24'd0, 0, 0, 0));
        pending_cmds.push_back(mk(ddmq_pkg::ACT_ADD, 3'd7, 24'd5, 0, 0, 0));
        for (int k = 0; k < 4; k++)
            pending_cmds.push_back(mk(ddmq_pkg::ACT_ADD, ddmq_pkg::DIR_BACK,
                                      24'(100 + k), 0, 0, 0));
        pending_cmds.push_back(mk(ddmq_pkg::ACT_GOTO, 0, 0, 100, 100, 0));
        for (int k = 0; k < 5; k++)
            pending_cmds.push_back(mk(ddmq_pkg::ACT_DISPATCH, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ddmq_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ddmq_pkg::ACT_SET_POSE, 0, 0, -2048, 2047, 16'hFFFF));
        pending_cmds.push_back(mk(ddmq_pkg::ACT_GOTO, 0, 0, -2048, 2047, 0));
        pending_cmds.push_back(mk(ddmq_pkg::ACT_GOTO, 0, 0, 2047, -2048, 0));
        pending_cmds.push_back(mk(3'd7, 0, 0, 0, 0, 0));
        for (int k = 0; k < 5; k++)
            pending_cmds.push_back(mk(ddmq_pkg::ACT_DISPATCH, 0, 0, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: cfg = '{20'd65535, 20'hFFFFF, 20'd255, 20'd255};
                1: cfg = '{20'd0, 20'd0, 20'd0, 20'd0};
                2: cfg = '{20'd272, 20'd1000, 20'd1, 20'd1};
                default: cfg = '{20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom)};
            endcase
            for (int r = 0; r < 4; r++) cfg_write(2'(r), cfg[r]);
            i_cfg_valid <= 1'b0;
            idle_pct = (ph % 3 == 0) ? 10 : (ph % 3 == 1) ? 64 : 0;
            for (int k = 0; k < 385; k++) pending_cmds.push_back(rand_cmd());
            drain();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: diff_drive_motion_command_queue_unit.f
design/ddmq_pkg.sv
design/ddmq_cordic.sv
design/diff_drive_motion_command_queue_unit.sv
tb/tb_top.sv
